// ===== rtl/rcfc_pkg.sv =====
`timescale 1ns / 1ps

package rcfc_pkg;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 16;
    localparam int TBL_DEPTH  = 256;
    localparam int TBL_ADDR_W = 8;
    localparam int NUM_STAGES = 7;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_LSB = 2;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_DATA    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] SEL_ROTOR     = 2'd0;
    localparam logic [1:0] SEL_INV_ROTOR = 2'd1;
    localparam logic [1:0] SEL_REFLECTOR = 2'd2;
    localparam logic [1:0] SEL_OFFSET    = 2'd3;

    localparam logic REG_DIRECTION = 1'b0;
    localparam logic REG_START     = 1'b1;

    localparam logic DIR_OLD_TO_NEW = 1'b0;

    typedef struct packed {
        logic              direction;
        logic [POS_W-1:0]  start_position;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] val;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] ph;
        logic              dir;
        logic              eob;
        logic              mid7;
    } t_item;

endpackage

// ===== rtl/rcfc_if.sv =====
`timescale 1ns / 1ps

interface rcfc_in_if import rcfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [1:0]        table_select;
    logic [BYTE_W-1:0] table_index;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_block;

    modport source (
        output valid, kind, table_select, table_index, data_byte, end_of_block,
        input  ready
    );
    modport sink (
        input  valid, kind, table_select, table_index, data_byte, end_of_block,
        output ready
    );
endinterface

interface rcfc_out_if import rcfc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] result_byte;
    logic              high_bit_seen;
    logic              end_of_block_out;

    modport source (
        output valid, result_byte, high_bit_seen, end_of_block_out,
        input  ready
    );
    modport sink (
        input  valid, result_byte, high_bit_seen, end_of_block_out,
        output ready
    );
endinterface

// ===== rtl/rcfc_ram.sv =====
`timescale 1ns / 1ps

module rcfc_ram import rcfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [TBL_ADDR_W-1:0] i_waddr,
    input  logic [BYTE_W-1:0]     i_wdata,
    input  logic                  i_re_a,
    input  logic [TBL_ADDR_W-1:0] i_raddr_a,
    output logic [BYTE_W-1:0]     o_rdata_a,
    input  logic                  i_re_b,
    input  logic [TBL_ADDR_W-1:0] i_raddr_b,
    output logic [BYTE_W-1:0]     o_rdata_b
);

    logic [BYTE_W-1:0] r_mem [TBL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            o_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== rtl/rcfc_regs.sv =====
`timescale 1ns / 1ps

module rcfc_regs import rcfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    logic             r_direction;
    logic [POS_W-1:0] r_start;
    logic             w_wr;
    logic             w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[REG_IDX_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_start     <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_DIRECTION: r_direction <= pwdata[0];
                REG_START:     r_start     <= pwdata[POS_W-1:0];
                default:       r_start     <= r_start;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_DIRECTION: prdata = {{(APB_DATA_W-1){1'b0}}, r_direction};
            REG_START:     prdata = {{(APB_DATA_W-POS_W){1'b0}}, r_start};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg.direction      = r_direction;
    assign o_cfg.start_position = r_start;

endmodule

// ===== rtl/rcfc_pipe.sv =====
`timescale 1ns / 1ps

module rcfc_pipe import rcfc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    rcfc_in_if.sink           i_in,
    rcfc_out_if.source        o_out
);

    logic [POS_W-1:0]        r_pos;
    logic [BYTE_W-1:0]       r_off_mem [TBL_DEPTH];
    logic [BYTE_W-1:0]       r_off_q;
    logic [NUM_STAGES:1]     r_v;
    t_item                   r_it [NUM_STAGES:1];
    t_item                   n_it [NUM_STAGES:1];
    logic [NUM_STAGES+1:1]   w_en;
    logic                    w_busy;
    logic                    w_acc;
    logic                    w_load;
    logic                    w_data;
    logic                    w_restart;

    logic [BYTE_W-1:0] w_f, w_s, w_mid, w_res;
    logic [BYTE_W-1:0] w_addr_rot_a, w_addr_refl_a, w_addr_inv_a;
    logic [BYTE_W-1:0] w_addr_rot_b, w_addr_refl_b, w_addr_inv_b;
    logic [BYTE_W-1:0] w_q_rot_a, w_q_refl_a, w_q_inv_a;
    logic [BYTE_W-1:0] w_q_rot_b, w_q_refl_b, w_q_inv_b;

    logic              r_out_v;
    logic [BYTE_W-1:0] r_out_res;
    logic              r_out_hb;
    logic              r_out_eob;

    // stage enables ripple back from the output register
    always_comb begin
        w_en[NUM_STAGES+1] = !r_out_v || o_out.ready;
        for (int k = NUM_STAGES; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign w_busy = |r_v;

    // table loads wait until no data item is reading the tables
    always_comb begin
        unique case (i_in.kind)
            KIND_LOAD: i_in.ready = !w_busy;
            KIND_DATA: i_in.ready = w_en[1];
            default:   i_in.ready = 1'b1;
        endcase
    end

    assign w_acc     = i_in.valid && i_in.ready;
    assign w_load    = w_acc && (i_in.kind == KIND_LOAD);
    assign w_data    = w_acc && (i_in.kind == KIND_DATA);
    assign w_restart = w_acc && (i_in.kind == KIND_RESTART);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (w_restart) begin
            r_pos <= i_cfg.start_position;
        end else if (w_data) begin
            r_pos <= r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (i_in.table_select == SEL_OFFSET)) begin
            r_off_mem[i_in.table_index] <= i_in.data_byte;
        end
        if (w_en[1]) begin
            r_off_q <= r_off_mem[r_pos[BYTE_W-1:0]];
        end
    end

    rcfc_ram u_rotor (
        .i_clk     (i_clk),
        .i_we      (w_load && (i_in.table_select == SEL_ROTOR)),
        .i_waddr   (i_in.table_index),
        .i_wdata   (i_in.data_byte),
        .i_re_a    (w_en[2]),
        .i_raddr_a (w_addr_rot_a),
        .o_rdata_a (w_q_rot_a),
        .i_re_b    (w_en[5]),
        .i_raddr_b (w_addr_rot_b),
        .o_rdata_b (w_q_rot_b)
    );

    rcfc_ram u_reflector (
        .i_clk     (i_clk),
        .i_we      (w_load && (i_in.table_select == SEL_REFLECTOR)),
        .i_waddr   (i_in.table_index),
        .i_wdata   (i_in.data_byte),
        .i_re_a    (w_en[3]),
        .i_raddr_a (w_addr_refl_a),
        .o_rdata_a (w_q_refl_a),
        .i_re_b    (w_en[6]),
        .i_raddr_b (w_addr_refl_b),
        .o_rdata_b (w_q_refl_b)
    );

    rcfc_ram u_inv_rotor (
        .i_clk     (i_clk),
        .i_we      (w_load && (i_in.table_select == SEL_INV_ROTOR)),
        .i_waddr   (i_in.table_index),
        .i_wdata   (i_in.data_byte),
        .i_re_a    (w_en[4]),
        .i_raddr_a (w_addr_inv_a),
        .o_rdata_a (w_q_inv_a),
        .i_re_b    (w_en[7]),
        .i_raddr_b (w_addr_inv_b),
        .o_rdata_b (w_q_inv_b)
    );

    always_comb begin
        n_it[1].val    = i_in.data_byte;
        n_it[1].first  = r_pos[BYTE_W-1:0];
        n_it[1].second = '0;
        n_it[1].ph     = r_pos[POS_W-1:BYTE_W];
        n_it[1].dir    = i_cfg.direction;
        n_it[1].eob    = i_in.end_of_block;
        n_it[1].mid7   = 1'b0;

        // first pass: decipher in the source format
        w_f = (r_it[1].dir == DIR_OLD_TO_NEW) ? r_it[1].first : r_off_q;
        w_s = (r_it[1].dir == DIR_OLD_TO_NEW) ? r_off_q : r_it[1].first;
        n_it[2]        = r_it[1];
        n_it[2].first  = w_f;
        n_it[2].second = w_s;
        w_addr_rot_a   = r_it[1].val + w_f;

        n_it[3]       = r_it[2];
        w_addr_refl_a = w_q_rot_a + r_it[2].ph;

        n_it[4]      = r_it[3];
        w_addr_inv_a = w_q_refl_a - r_it[3].ph;

        // second pass: encipher in the target format
        w_mid        = w_q_inv_a - r_it[4].first;
        n_it[5]      = r_it[4];
        n_it[5].val  = w_mid;
        n_it[5].mid7 = w_mid[BYTE_W-1];
        w_addr_rot_b = w_mid + r_it[4].second;

        n_it[6]       = r_it[5];
        w_addr_refl_b = w_q_rot_b + r_it[5].ph;

        n_it[7]      = r_it[6];
        w_addr_inv_b = w_q_refl_b - r_it[6].ph;

        w_res = w_q_inv_b - r_it[7].second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= w_data;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_en[NUM_STAGES+1]) begin
                r_out_v <= r_v[NUM_STAGES];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_it[1] <= n_it[1];
        end
        for (int k = 2; k <= NUM_STAGES; k++) begin
            if (w_en[k]) begin
                r_it[k] <= n_it[k];
            end
        end
        if (w_en[NUM_STAGES+1]) begin
            r_out_res <= w_res;
            r_out_hb  <= r_it[NUM_STAGES].mid7;
            r_out_eob <= r_it[NUM_STAGES].eob;
        end
    end

    assign o_out.valid            = r_out_v;
    assign o_out.result_byte      = r_out_res;
    assign o_out.high_bit_seen    = r_out_hb;
    assign o_out.end_of_block_out = r_out_eob;

endmodule

// ===== rtl/rotor_cipher_format_converter.sv =====
`timescale 1ns / 1ps

// Converts a byte stream between the old and new single-rotor cipher formats, one
// data item per cycle while the result output is not stalled. The offset table is
// read at the edge that accepts a data item, then come the chained rotor, reflector
// and inverse rotor reads of the two passes (each table has two read ports, one per
// pass), then the output register. Up to eight data items are in flight, and input
// keeps being accepted while a finished result waits. Table-load items are accepted
// only once no data item is in the table-reading stages, so a load right behind a
// data item waits until that item reaches the output register, longer while the
// result output is stalled; restart and load items give no result. Tables hold
// nothing useful until loaded; there is no clearing pass after reset. Registers sit
// at byte addresses 0 (direction) and 4 (start position).

module rotor_cipher_format_converter import rcfc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rcfc_in_if.sink               i_in,
    rcfc_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg w_cfg;

    rcfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    rcfc_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/rcfc_checker.sv =====
`timescale 1ns / 1ps

module rcfc_checker import rcfc_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic [1:0]        i_in_kind,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [BYTE_W-1:0] i_out_result_byte,
    input logic              i_out_high_bit,
    input logic              i_out_eob
);

    localparam int MAX_INFLIGHT = NUM_STAGES + 1;

    logic [3:0] r_count;
    logic       w_in_data;
    logic       w_out_acc;

    assign w_in_data = i_in_valid && i_in_ready && (i_in_kind == KIND_DATA);
    assign w_out_acc = i_out_valid && i_out_ready;

    // data items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + {3'b0, w_in_data} - {3'b0, w_out_acc};
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_result_byte)
            && $stable(i_out_high_bit) && $stable(i_out_eob))
        else $error("result changed while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_count != 4'd0)
        else $error("result without a data item");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 4'(MAX_INFLIGHT))
        else $error("more items in flight than stages");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind rotor_cipher_format_converter rcfc_checker u_rcfc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_kind         (i_in.kind),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_result_byte (o_out.result_byte),
    .i_out_high_bit    (o_out.high_bit_seen),
    .i_out_eob         (o_out.end_of_block_out)
);

// ===== verif/rotor_cipher_format_converter_tb.sv =====
`timescale 1ns / 1ps

import rcfc_pkg::*;

typedef struct packed {
    logic [BYTE_W-1:0] result_byte;
    logic              high_bit_seen;
    logic              end_of_block;
} t_converted;

class rotor_scoreboard;
    logic [BYTE_W-1:0] rotor_tbl [TBL_DEPTH];
    logic [BYTE_W-1:0] inv_rotor_tbl [TBL_DEPTH];
    logic [BYTE_W-1:0] reflector_tbl [TBL_DEPTH];
    logic [BYTE_W-1:0] offset_tbl [TBL_DEPTH];
    logic              direction;
    logic [POS_W-1:0]  start_pos;
    logic [POS_W-1:0]  position;
    t_converted        expected_bytes[$];
    int                errors;
    int                n_data;
    int                n_loads;
    int                n_restarts;
    int                n_checked;

    function void set_config(input logic dir, input logic [POS_W-1:0] start);
        direction = dir;
        start_pos = start;
    endfunction

    // shift in, rotor, shifted reflector, inverse rotor, shift out
    function logic [BYTE_W-1:0] cipher_pass(input logic [BYTE_W-1:0] x,
                                            input logic [BYTE_W-1:0] shift,
                                            input logic [BYTE_W-1:0] refl_shift);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] ix;
        ix = x + shift;
        a = rotor_tbl[ix];
        ix = a + refl_shift;
        b = reflector_tbl[ix];
        ix = b - refl_shift;
        c = inv_rotor_tbl[ix];
        return c - shift;
    endfunction

    function void note_input(input logic [1:0] kind, input logic [1:0] sel,
                             input logic [BYTE_W-1:0] idx,
                             input logic [BYTE_W-1:0] value, input logic eob);
        logic [BYTE_W-1:0] low_shift;
        logic [BYTE_W-1:0] table_shift;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
        logic [BYTE_W-1:0] mid;
        t_converted        exp_item;
        if (kind == KIND_LOAD) begin
            n_loads++;
            case (sel)
                SEL_ROTOR:     rotor_tbl[idx] = value;
                SEL_INV_ROTOR: inv_rotor_tbl[idx] = value;
                SEL_REFLECTOR: reflector_tbl[idx] = value;
                default:       offset_tbl[idx] = value;
            endcase
        end else if (kind == KIND_RESTART) begin
            n_restarts++;
            position = start_pos;
        end else if (kind == KIND_DATA) begin
            n_data++;
            low_shift = position[BYTE_W-1:0];
            table_shift = offset_tbl[low_shift];
            first = (direction == DIR_OLD_TO_NEW) ? low_shift : table_shift;
            second = (direction == DIR_OLD_TO_NEW) ? table_shift : low_shift;
            mid = cipher_pass(value, first, position[POS_W-1:BYTE_W]);
            exp_item.result_byte = cipher_pass(mid, second, position[POS_W-1:BYTE_W]);
            exp_item.high_bit_seen = mid[BYTE_W-1];
            exp_item.end_of_block = eob;
            expected_bytes.push_back(exp_item);
            position = position + 1'b1;
        end
    endfunction

    function void check_result(input logic [BYTE_W-1:0] res, input logic hb,
                               input logic eob);
        t_converted exp_item;
        if (expected_bytes.size() == 0) begin
            errors++;
            $display("%0t: unexpected item: result_byte %h high_bit_seen %b eob %b",
                     $time, res, hb, eob);
            return;
        end
        exp_item = expected_bytes.pop_front();
        n_checked++;
        if (res !== exp_item.result_byte) begin
            errors++;
            $display("%0t: result_byte expected %h actual %h",
                     $time, exp_item.result_byte, res);
        end
        if (hb !== exp_item.high_bit_seen) begin
            errors++;
            $display("%0t: high_bit_seen expected %b actual %b",
                     $time, exp_item.high_bit_seen, hb);
        end
        if (eob !== exp_item.end_of_block) begin
            errors++;
            $display("%0t: end_of_block_out expected %b actual %b",
                     $time, exp_item.end_of_block, eob);
        end
    endfunction
endclass

module rotor_cipher_format_converter_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [APB_ADDR_W-1:0] ADDR_DIRECTION =
        APB_ADDR_W'({REG_DIRECTION}) << REG_IDX_LSB;
    localparam logic [APB_ADDR_W-1:0] ADDR_START =
        APB_ADDR_W'({REG_START}) << REG_IDX_LSB;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS = 112;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  idle_on;

    rotor_scoreboard sb = new();

    rcfc_in_if  in_if ();
    rcfc_out_if out_if ();

    rotor_cipher_format_converter uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // sink side: random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 3) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
            sb.check_result(out_if.result_byte, out_if.high_bit_seen,
                            out_if.end_of_block_out);
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("%0t: timeout, %0d items still expected",
                         $time, sb.expected_bytes.size());
                $display("rotor_cipher_format_converter_tb: done, errors");
                $finish;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send(input logic [1:0] kind, input logic [1:0] sel,
                        input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] value,
                        input logic eob);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= kind;
        in_if.table_select <= sel;
        in_if.table_index <= idx;
        in_if.data_byte <= value;
        in_if.end_of_block <= eob;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_input(kind, sel, idx, value, eob);
        @(negedge i_clk);
    endtask

    task automatic send_data(input logic [BYTE_W-1:0] value, input logic eob);
        send(KIND_DATA, 2'($urandom), 8'($urandom), value, eob);
    endtask

    task automatic wait_results;
        in_if.valid <= 1'b0;
        while (sb.expected_bytes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apb_check(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] exp_data);
        logic [APB_DATA_W-1:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        got = prdata;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        if (got !== exp_data) begin
            sb.errors++;
            $display("%0t: register at %0d expected %h actual %h",
                     $time, addr, exp_data, got);
        end
    endtask

    // only while idle: outputs drained and the pipe given time to settle
    task automatic set_config(input logic dir, input logic [POS_W-1:0] start);
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        apb_write(ADDR_DIRECTION, APB_DATA_W'(dir));
        apb_write(ADDR_START, APB_DATA_W'(start));
        apb_check(ADDR_DIRECTION, APB_DATA_W'(dir));
        apb_check(ADDR_START, APB_DATA_W'(start));
        sb.set_config(dir, start);
    endtask

    task automatic random_phase(input logic dir, input logic [POS_W-1:0] start,
                                input bit pause_midway);
        int count;
        int pick;
        set_config(dir, start);
        send(KIND_RESTART, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        count = 0;
        while (count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                send_data(8'($urandom), $urandom_range(0, 7) == 0);
                count++;
            end else if (pick < 88) begin
                send(KIND_LOAD, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                count++;
            end else if (pick < 95) begin
                send(KIND_RESTART, 2'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom));
                count++;
            end else begin
                send(KIND_UNUSED, 2'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
            end
            if (pause_midway && count == PHASE_ITEMS / 2)
                wait_results();
        end
    endtask

    initial begin
        logic [1:0] sel_list [4];
        sel_list = '{SEL_ROTOR, SEL_INV_ROTOR, SEL_REFLECTOR, SEL_OFFSET};
        idle_on = 1'b1;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = KIND_LOAD;
        in_if.table_select = SEL_ROTOR;
        in_if.table_index = '0;
        in_if.data_byte = '0;
        in_if.end_of_block = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sb.set_config(DIR_OLD_TO_NEW, '0);
        sb.position = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        apb_check(ADDR_DIRECTION, '0);
        apb_check(ADDR_START, '0);

        // every table entry written before any data item reads it
        foreach (sel_list[s])
            for (int i = 0; i < TBL_DEPTH; i++)
                send(KIND_LOAD, sel_list[s], 8'(i), 8'($urandom), 1'($urandom));

        send_data(8'h00, 1'b0);
        send_data(8'hff, 1'b1);
        send_data(8'h80, 1'b0);
        send_data(8'h7f, 1'b1);
        send_data(8'h01, 1'b0);
        send_data(8'hfe, 1'b0);
        send(KIND_UNUSED, 2'b11, 8'hff, 8'hff, 1'b1);
        send(KIND_RESTART, 2'b11, 8'hff, 8'hff, 1'b1);
        send_data(8'h55, 1'b0);
        send(KIND_LOAD, SEL_ROTOR, 8'h00, 8'hff, 1'b0);
        send_data(8'haa, 1'b1);
        send(KIND_LOAD, SEL_INV_ROTOR, 8'hff, 8'h00, 1'b1);
        send(KIND_LOAD, SEL_REFLECTOR, 8'h80, 8'h7f, 1'b0);
        send(KIND_LOAD, SEL_OFFSET, 8'h00, 8'h80, 1'b0);
        send_data(8'h00, 1'b1);
        send_data(8'hff, 1'b0);

        // position wrap from 65535 to 0, new to old
        set_config(1'b1, 16'hffff);
        send(KIND_RESTART, 2'b00, 8'h00, 8'h00, 1'b0);
        send_data(8'hff, 1'b0);
        send_data(8'h00, 1'b0);
        send_data(8'h80, 1'b1);

        random_phase(1'b0, 16'h0000, 1'b0);
        random_phase(1'b1, 16'hffff, 1'b1);
        random_phase(1'b0, 16'h12fe, 1'b0);
        idle_on = 1'b0;
        random_phase(1'b1, 16'($urandom), 1'b0);

        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.expected_bytes.size() != 0) begin
            sb.errors++;
            $display("%0t: %0d expected items never arrived",
                     $time, sb.expected_bytes.size());
        end
        $display("run covered %0d data items, %0d table loads, %0d restarts, %0d checked",
                 sb.n_data, sb.n_loads, sb.n_restarts, sb.n_checked);
        $display("both directions, start positions 0, 65535, 0x12fe and one random value");
        if (sb.errors == 0)
            $display("rotor_cipher_format_converter_tb: done, clean");
        else
            $display("rotor_cipher_format_converter_tb: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rcfc_pkg.sv
rtl/rcfc_if.sv
rtl/rcfc_ram.sv
rtl/rcfc_regs.sv
rtl/rcfc_pipe.sv
rtl/rotor_cipher_format_converter.sv
rtl/rcfc_checker.sv
verif/rotor_cipher_format_converter_tb.sv
